>>> hdl/tkds_pkg.sv
package tkds_pkg;

  localparam int MAX_KEEP = 64;
  localparam int CNT_W    = $clog2(MAX_KEEP + 1);

  localparam logic [15:0] SENT_SMALL = 16'h7bff;
  localparam logic [15:0] SENT_LARGE = 16'hfbff;
  localparam logic [31:0] EMPTY_ID   = 32'hffffffff;

  localparam logic [1:0] REG_ORDER_MODE = 2'd0;
  localparam logic [1:0] REG_KEEP_COUNT = 2'd1;
  localparam logic [1:0] REG_LIST_SIZE  = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_FLUSH,
    S_CLEAR
  } state_t;

  // control broadcast to every cell of the chain
  typedef struct packed {
    logic        ins_valid;
    logic        mode;
    logic [15:0] ins_d;
    logic [31:0] ins_id;
    logic        shift;
    logic        clear;
    logic [15:0] sent;
  } cell_ctl_t;

  function automatic logic half_is_nan(input logic [15:0] h);
    return h[14:0] > 15'h7c00;
  endfunction

  function automatic logic signed [16:0] half_key(input logic [15:0] h);
    logic signed [16:0] m;
    m = signed'({2'b00, h[14:0]});
    return h[15] ? -m : m;
  endfunction

  // a strictly better than b
  function automatic logic better(input logic mode, input logic [15:0] a,
                                  input logic [15:0] b);
    if (half_is_nan(a) || half_is_nan(b)) return 1'b0;
    if (mode) return half_key(a) < half_key(b);
    return half_key(a) > half_key(b);
  endfunction

  function automatic logic key_eq(input logic [15:0] a, input logic [15:0] b);
    return (a[14:0] == b[14:0]) && ((a[15] == b[15]) || (a[14:0] == 15'd0));
  endfunction

  function automatic logic [CNT_W-1:0] eff_keep(input logic [6:0] k);
    if (k == 7'd0) return CNT_W'(1);
    if (32'(k) > MAX_KEEP) return CNT_W'(MAX_KEEP);
    return CNT_W'(k);
  endfunction

  function automatic logic [15:0] sentinel(input logic mode);
    return mode ? SENT_SMALL : SENT_LARGE;
  endfunction

endpackage

>>> hdl/tkds_cell.sv
module tkds_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  tkds_pkg::cell_ctl_t ctl,
  input  logic                active,
  input  logic                prev_better,
  input  logic [15:0]         prev_d,
  input  logic [31:0]         prev_id,
  output logic                better_o,
  output logic [15:0]         d_o,
  output logic [31:0]         id_o
);

  logic [15:0] d_r, d_nxt;
  logic [31:0] id_r, id_nxt;

  assign better_o = active && ctl.ins_valid && tkds_pkg::better(ctl.mode, ctl.ins_d, d_r);
  assign d_o  = d_r;
  assign id_o = id_r;

  always_comb begin
    d_nxt  = d_r;
    id_nxt = id_r;
    if (ctl.clear) begin
      d_nxt  = ctl.sent;
      id_nxt = tkds_pkg::EMPTY_ID;
    end else if (ctl.shift) begin
      d_nxt  = prev_d;
      id_nxt = prev_id;
    end else if (active && ctl.ins_valid) begin
      // hand down from the neighbour, or take the new entry at the insert point
      if (prev_better) begin
        d_nxt  = prev_d;
        id_nxt = prev_id;
      end else if (better_o) begin
        d_nxt  = ctl.ins_d;
        id_nxt = ctl.ins_id;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r  <= tkds_pkg::SENT_SMALL;
      id_r <= tkds_pkg::EMPTY_ID;
    end else begin
      d_r  <= d_nxt;
      id_r <= id_nxt;
    end
  end

endmodule

>>> hdl/tkds_stack.sv
module tkds_stack (
  input  logic        clk,
  input  logic        push,
  input  logic        pop,
  input  logic [15:0] push_d,
  input  logic [31:0] push_id,
  output logic [15:0] top_d,
  output logic [31:0] top_id
);

  logic [15:0] d_r  [tkds_pkg::MAX_KEEP];
  logic [31:0] id_r [tkds_pkg::MAX_KEEP];

  assign top_d  = d_r[0];
  assign top_id = id_r[0];

  for (genvar i = 0; i < tkds_pkg::MAX_KEEP; i++) begin : g_slot
    always_ff @(posedge clk) begin
      if (push) begin
        if (i == 0) begin
          d_r[i]  <= push_d;
          id_r[i] <= push_id;
        end else begin
          d_r[i]  <= d_r[(i == 0) ? 0 : i - 1];
          id_r[i] <= id_r[(i == 0) ? 0 : i - 1];
        end
      end else if (pop && (i < tkds_pkg::MAX_KEEP - 1)) begin
        d_r[i]  <= d_r[(i < tkds_pkg::MAX_KEEP - 1) ? i + 1 : i];
        id_r[i] <= id_r[(i < tkds_pkg::MAX_KEEP - 1) ? i + 1 : i];
      end
    end
  end

endmodule

>>> hdl/topk_distance_select_top.sv
// Streaming top-k selector for half-precision distances of one query. While a
// query streams in, one distance is accepted every cycle; each passes a two-stage
// id pipeline (bucket * list_size, then + position) and is then inserted into
// a chain of MAX_KEEP compare cells held best first. After the item with tlast,
// no request is taken while it is in the id pipeline, during the drain and in
// the clear state. The drain pops the k kept cells from the chain tail into a
// stack that regroups equal distances, and pops the stack to the output group
// by group, where a group is the whole set when order_mode is 0 and each run of
// equal distances when it is 1. Results leave in descending distance, tlast on
// the last of k. Writing order_mode or keep_count empties the kept set;
// list_size does not.
module topk_distance_select_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // distance, bucket_number, list_position
  input  logic        in_tlast,   // is_last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // best_distance, best_id
  output logic        out_tlast,  // last_result
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  localparam int N = tkds_pkg::MAX_KEEP;
  localparam int W = tkds_pkg::CNT_W;

  tkds_pkg::state_t state_r, state_nxt;

  logic         mode_r;
  logic [W-1:0] keff_r;
  logic [15:0]  lsize_r;

  logic         s1_v_r, s1_last_r, s2_v_r, s2_last_r;
  logic [15:0]  s1_d_r, s1_pos_r, s2_d_r;
  logic [31:0]  s1_prod_r, s2_id_r;

  logic [W-1:0] pops_r, pops_nxt, stk_r, stk_nxt;

  logic         out_v_r, out_v_nxt, out_last_r, out_last_nxt;
  logic [15:0]  out_d_r, out_d_nxt;
  logic [31:0]  out_id_r, out_id_nxt;

  logic         in_acc, out_free, can_push, do_push, do_pop, cfg_clr;
  logic [15:0]  top_d;
  logic [31:0]  top_id;

  tkds_pkg::cell_ctl_t ctl;

  logic        cell_bt [N];
  logic [15:0] cell_d  [N];
  logic [31:0] cell_id [N];

  assign in_acc   = in_tvalid && in_tready;
  assign out_free = !out_v_r || out_tready;
  assign in_tready = (state_r == tkds_pkg::S_IDLE) && !(s1_v_r && s1_last_r)
                     && !(s2_v_r && s2_last_r);

  // configuration
  assign cfg_clr = cfg_we && ((cfg_index == tkds_pkg::REG_ORDER_MODE) ||
                              (cfg_index == tkds_pkg::REG_KEEP_COUNT));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= 1'b1;
      keff_r  <= W'(8);
      lsize_r <= 16'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        tkds_pkg::REG_ORDER_MODE: mode_r  <= cfg_wdata[0];
        tkds_pkg::REG_KEEP_COUNT: keff_r  <= tkds_pkg::eff_keep(cfg_wdata[6:0]);
        tkds_pkg::REG_LIST_SIZE:  lsize_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // id pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= in_acc;
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_prod_r <= 32'(in_tdata[31:16]) * 32'(lsize_r);
    s1_d_r    <= in_tdata[15:0];
    s1_pos_r  <= in_tdata[47:32];
    s1_last_r <= in_tlast;
    s2_id_r   <= s1_prod_r + {16'd0, s1_pos_r};
    s2_d_r    <= s1_d_r;
    s2_last_r <= s1_last_r;
  end

  // cell chain, tail fixed at the last cell
  assign can_push = (pops_r != '0) && ((stk_r == '0) || !mode_r ||
                    tkds_pkg::key_eq(cell_d[N-1], top_d));
  assign do_push  = (state_r == tkds_pkg::S_POP) && can_push;
  assign do_pop   = (state_r == tkds_pkg::S_FLUSH) && out_free;

  always_comb begin
    ctl.ins_valid = s2_v_r;
    ctl.mode      = mode_r;
    ctl.ins_d     = s2_d_r;
    ctl.ins_id    = s2_id_r;
    ctl.shift     = do_push;
    ctl.clear     = cfg_clr || (state_r == tkds_pkg::S_CLEAR);
    ctl.sent      = (cfg_we && (cfg_index == tkds_pkg::REG_ORDER_MODE)) ?
                    tkds_pkg::sentinel(cfg_wdata[0]) : tkds_pkg::sentinel(mode_r);
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic        act;
    logic        pb;
    logic [15:0] pd;
    logic [31:0] pid;
    assign act = ((W+1)'(i) + {1'b0, keff_r}) >= (W+1)'(N);
    if (i == 0) begin : g_head
      assign pb  = 1'b0;
      assign pd  = ctl.sent;
      assign pid = tkds_pkg::EMPTY_ID;
    end else begin : g_body
      assign pb  = cell_bt[i-1];
      assign pd  = cell_d[i-1];
      assign pid = cell_id[i-1];
    end
    tkds_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .active      (act),
      .prev_better (pb),
      .prev_d      (pd),
      .prev_id     (pid),
      .better_o    (cell_bt[i]),
      .d_o         (cell_d[i]),
      .id_o        (cell_id[i])
    );
  end

  tkds_stack u_stack (
    .clk     (clk),
    .push    (do_push),
    .pop     (do_pop),
    .push_d  (cell_d[N-1]),
    .push_id (cell_id[N-1]),
    .top_d   (top_d),
    .top_id  (top_id)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tkds_pkg::S_IDLE:  if (s2_v_r && s2_last_r) state_nxt = tkds_pkg::S_POP;
      tkds_pkg::S_POP:   if (!can_push) state_nxt = tkds_pkg::S_FLUSH;
      tkds_pkg::S_FLUSH: begin
        if (out_free && (stk_r == W'(1)))
          state_nxt = (pops_r == '0) ? tkds_pkg::S_CLEAR : tkds_pkg::S_POP;
      end
      tkds_pkg::S_CLEAR: state_nxt = tkds_pkg::S_IDLE;
      default:           state_nxt = tkds_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    pops_nxt     = pops_r;
    stk_nxt      = stk_r;
    out_v_nxt    = out_v_r && !out_tready;
    out_d_nxt    = out_d_r;
    out_id_nxt   = out_id_r;
    out_last_nxt = out_last_r;
    case (state_r)
      tkds_pkg::S_IDLE: begin
        pops_nxt = keff_r;
        stk_nxt  = '0;
      end
      tkds_pkg::S_POP: begin
        if (can_push) begin
          pops_nxt = pops_r - W'(1);
          stk_nxt  = stk_r + W'(1);
        end
      end
      tkds_pkg::S_FLUSH: begin
        if (out_free) begin
          stk_nxt      = stk_r - W'(1);
          out_v_nxt    = 1'b1;
          out_d_nxt    = top_d;
          out_id_nxt   = top_id;
          out_last_nxt = (pops_r == '0) && (stk_r == W'(1));
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tkds_pkg::S_IDLE;
      pops_r  <= '0;
      stk_r   <= '0;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pops_r  <= pops_nxt;
      stk_r   <= stk_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_d_r    <= out_d_nxt;
    out_id_r   <= out_id_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {out_id_r, out_d_r};
  assign out_tlast  = out_last_r;

  a_stk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(stk_r) + 32'(pops_r)) <= N)
    else $error("stack and pending pops exceed capacity");

  a_flush_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tkds_pkg::S_FLUSH) |-> (stk_r != '0))
    else $error("flush with empty stack");

  a_busy_no_req: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != tkds_pkg::S_IDLE) |-> !in_tready)
    else $error("request taken during drain");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (do_pop && out_last_nxt) |=> (state_r == tkds_pkg::S_CLEAR))
    else $error("final result without clear");

endmodule

>>> tb/sv/topk_distance_select_top_tb.sv
module topk_distance_select_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [15:0] dval;
    logic [31:0] id;
    logic        last;
  } kept_result_t;

  class topk_scoreboard;
    logic        mode;
    logic [6:0]  keep;
    logic [15:0] lsize;
    logic [15:0] slot_d[tkds_pkg::MAX_KEEP];
    logic [31:0] slot_id[tkds_pkg::MAX_KEEP];
    kept_result_t pending[$];
    int errors;

    function void clear_slots();
      for (int i = 0; i < tkds_pkg::MAX_KEEP; i++) begin
        slot_d[i]  = mode ? tkds_pkg::SENT_SMALL : tkds_pkg::SENT_LARGE;
        slot_id[i] = tkds_pkg::EMPTY_ID;
      end
    endfunction

    function int keep_eff();
      if (keep == 0) return 1;
      if (int'(keep) > tkds_pkg::MAX_KEEP) return tkds_pkg::MAX_KEEP;
      return int'(keep);
    endfunction

    function bit nan16(logic [15:0] h);
      return h[14:0] > 15'h7c00;
    endfunction

    function int key16(logic [15:0] h);
      int m;
      m = int'(h[14:0]);
      return h[15] ? -m : m;
    endfunction

    function bit beats(logic [15:0] a, logic [15:0] b);
      if (nan16(a) || nan16(b)) return 0;
      return mode ? key16(a) < key16(b) : key16(a) > key16(b);
    endfunction

    function void reset_state();
      mode = 1'b1;
      keep = 7'd8;
      lsize = 16'd1;
      errors = 0;
      clear_slots();
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] val);
      if (idx == tkds_pkg::REG_ORDER_MODE) begin
        mode = val[0];
        clear_slots();
      end else if (idx == tkds_pkg::REG_KEEP_COUNT) begin
        keep = val[6:0];
        clear_slots();
      end else if (idx == tkds_pkg::REG_LIST_SIZE) begin
        lsize = val;
      end
    endfunction

    function void note_request(logic [15:0] d, logic [15:0] bkt, logic [15:0] pos,
                               logic last);
      logic [31:0] id;
      logic [15:0] sd[tkds_pkg::MAX_KEEP];
      logic [31:0] sid[tkds_pkg::MAX_KEEP];
      logic [15:0] cd;
      logic [31:0] cid;
      int k, p, j;
      kept_result_t r;
      id = 32'(bkt) * 32'(lsize) + 32'(pos);
      k = keep_eff();
      if (beats(d, slot_d[k-1])) begin
        p = 0;
        while (p < k - 1 && !beats(d, slot_d[p])) p++;
        for (int i = k - 1; i > p; i--) begin
          slot_d[i] = slot_d[i-1];
          slot_id[i] = slot_id[i-1];
        end
        slot_d[p] = d;
        slot_id[p] = id;
      end
      if (!last) return;
      // stable insertion sort, descending by value
      for (int i = 0; i < k; i++) begin
        cd = slot_d[i];
        cid = slot_id[i];
        j = i;
        while (j > 0 && key16(sd[j-1]) < key16(cd)) begin
          sd[j] = sd[j-1];
          sid[j] = sid[j-1];
          j--;
        end
        sd[j] = cd;
        sid[j] = cid;
      end
      for (int i = 0; i < k; i++) begin
        r.dval = sd[i];
        r.id = sid[i];
        r.last = (i == k - 1);
        pending = {pending, r};
      end
      clear_slots();
    endfunction

    function void report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endfunction

    function void check_result(logic [47:0] data, logic last);
      kept_result_t e;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result %h last %b", data, last));
        return;
      end
      e = pending.pop_front();
      if (data[15:0] !== e.dval)
        report($sformatf("distance %h, want %h", data[15:0], e.dval));
      if (data[47:16] !== e.id)
        report($sformatf("id %h, want %h", data[47:16], e.id));
      if (last !== e.last)
        report($sformatf("last %b, want %b", last, e.last));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic        out_tlast;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_wdata = '0;

  topk_distance_select_top u_top (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  topk_scoreboard sb = new();
  int  idle_pct = 33;    // idling of the sender
  int  stall_pct = 33;   // stalling of the receiver
  bit  hold_off = 1'b0;
  bit  timed_out = 1'b0;
  int  quiet = 0;

  // check results at the edge
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tlast);
  end

  always @(posedge clk) begin
    if (!rst_n || hold_off) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > 20000) begin
      $display("** topk_distance_select_top: FAILED **");
      $finish;
    end
  end

  task automatic write_cfg(logic [1:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    sb.write_reg(idx, val);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // start at a clock edge; leave the request offered so the next can follow
  task automatic send_request(logic [15:0] d, logic [15:0] bkt, logic [15:0] pos,
                              logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {pos, bkt, d};
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
    sb.note_request(d, bkt, pos, last);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_distance();
    case ($urandom_range(9))
      0: return 16'h7c00 | 16'($urandom_range(1, 1023)) | (16'($urandom_range(1)) << 15);
      1: return $urandom_range(1) ? 16'h0000 : 16'h8000;
      2: return $urandom_range(1) ? 16'h7c00 : 16'hfc00;
      3: return $urandom_range(1) ? tkds_pkg::SENT_SMALL : tkds_pkg::SENT_LARGE;
      4: return 16'h3c00 | 16'($urandom_range(3));   // ties likely
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_query(int len);
    for (int i = 0; i < len; i++)
      send_request(pick_distance(), 16'($urandom), 16'($urandom), i == len - 1);
  endtask

  int sent = 0;
  int len;

  initial begin
    sb.reset_state();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // directed: extremes, signed zeros, NaN, infinities, ties, sentinels
    send_request(16'h0000, 16'hffff, 16'hffff, 1'b0);
    send_request(16'h8000, 16'h0000, 16'h0000, 1'b0);
    send_request(16'h7e00, 16'h0001, 16'h0001, 1'b0);
    send_request(16'hfc00, 16'h0002, 16'h0002, 1'b0);
    send_request(16'h7c00, 16'h0003, 16'h0003, 1'b0);
    send_request(16'h3c00, 16'h0004, 16'h0004, 1'b0);
    send_request(16'h3c00, 16'h0005, 16'h0005, 1'b0);
    send_request(tkds_pkg::SENT_SMALL, 16'h0006, 16'h0006, 1'b1);
    wait_drained();
    write_cfg(tkds_pkg::REG_ORDER_MODE, 16'd0);
    write_cfg(tkds_pkg::REG_KEEP_COUNT, 16'd0);
    write_cfg(tkds_pkg::REG_LIST_SIZE, 16'd0);
    send_request(tkds_pkg::SENT_LARGE, 16'h1234, 16'h0007, 1'b0);
    send_request(16'hffff, 16'h1234, 16'h0008, 1'b0);
    send_request(16'h7bff, 16'hffff, 16'hfffe, 1'b1);
    wait_drained();
    write_cfg(tkds_pkg::REG_KEEP_COUNT, 16'h007f);
    write_cfg(tkds_pkg::REG_LIST_SIZE, 16'hffff);
    send_request(16'h0001, 16'hffff, 16'hffff, 1'b1);
    wait_drained();
    write_cfg(tkds_pkg::REG_KEEP_COUNT, 16'd64);
    write_cfg(tkds_pkg::REG_ORDER_MODE, 16'd1);
    send_request(16'h8001, 16'h0000, 16'h0000, 1'b1);
    wait_drained();
    sent = 13;

    while (sent < 410) begin
      case ($urandom_range(3))
        0: write_cfg(tkds_pkg::REG_KEEP_COUNT, 16'($urandom_range(1, 8)));
        1: write_cfg(tkds_pkg::REG_ORDER_MODE, 16'($urandom_range(1)));
        2: write_cfg(tkds_pkg::REG_LIST_SIZE,
                     $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(4)));
        default: write_cfg(tkds_pkg::REG_KEEP_COUNT, 16'($urandom_range(0, 127)));
      endcase
      if (sent > 150 && sent < 200) begin
        idle_pct = 0;
        stall_pct = 0;
      end else begin
        idle_pct = 33;
        stall_pct = 33;
      end
      len = $urandom_range(1, 20);
      if (sent > 250 && sent < 280) begin
        // long receiver hold-off while the sender keeps going
        write_cfg(tkds_pkg::REG_KEEP_COUNT, 16'd64);
        hold_off = 1'b1;
        fork
          begin
            repeat (400) @(posedge clk);
            hold_off = 1'b0;
          end
        join_none
        random_query(len);
        random_query(3);
        random_query(2);
        wait_drained();
        wait fork;
        sent += 5;
      end else begin
        random_query(len);
      end
      sent += len;
      wait_drained();
    end

    wait_drained();
    if (sb.errors == 0) $display("** topk_distance_select_top: PASSED **");
    else $display("** topk_distance_select_top: FAILED **");
    $finish;
  end
endmodule
